/* sv/jhsd_pkg.sv */
package jhsd_pkg;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BITS,
    ST_FLUSH
  } jhsd_state_t;

  // What an accepted beat asks of the controller.
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_BYTE,
    ACT_MARK
  } jhsd_action_t;

  // Input item kinds.
  localparam logic [1:0] KIND_COUNT  = 2'd0;
  localparam logic [1:0] KIND_SYMBOL = 2'd1;
  localparam logic [1:0] KIND_SCAN   = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_SYMBOL  = 2'd0;
  localparam logic [1:0] STAT_EOI     = 2'd1;
  localparam logic [1:0] STAT_UNKNOWN = 2'd2;
  localparam logic [1:0] STAT_INVALID = 2'd3;

  // Byte codes seen in the scan.
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] MARK_EOI = 8'hD9;
  localparam logic [7:0] MARK_DNL = 8'hDC;

  localparam int COUNT_ENTRIES = 16;
  localparam int CODE_W        = 16;
  localparam int TAB_W         = 17;
  localparam int BUILD_CNT_W   = 9;
  localparam int LEN_W         = 5;

  typedef struct packed {
    logic accept;
    logic step;
    logic flush;
  } jhsd_cmd_t;

  typedef struct packed {
    jhsd_action_t action;
    logic         held_valid;
    logic         out_free;
  } jhsd_stat_t;

endpackage

/* sv/jpeg_huffman_symbol_decoder.sv */
// Sequence: a load beat is only accepted; a scan byte is accepted, then takes eight
// decode steps (one code bit and one length-table compare each) and one flush step.
// A new beat is taken only when the previous one is through; the serial bit decoder
// with its single length-table port stalls while a held result waits on a full output.
// Reset (rst, synchronous, active high) empties the length tables (no codes), clears the
// partial code, the stuffing flag and the output; the symbol table is not cleared.
module jpeg_huffman_symbol_decoder #(
  parameter int MAX_CODE_BITS = 16,
  parameter int SYMBOL_SLOTS  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // index [7:0], value [15:8]
  input  logic [1:0]  s_tuser,   // kind [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // symbol [7:0]
  output logic [1:0]  m_tuser,   // status [1:0]
  output logic        m_tlast
);
  import jhsd_pkg::*;

  // Command and status between the sequencer and the datapath.
  jhsd_cmd_t  cmd;
  jhsd_stat_t stat;

  // The controller accepts a beat only when idle, walks the eight bits of a
  // scan byte and then releases the final held result with its last flag set.
  jhsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the length tables, the symbol memory, the partial code
  // and a one-result holding stage, so that the last result of a byte can be
  // marked before it is sent.
  jhsd_dp #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .SYMBOL_SLOTS  (SYMBOL_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* sv/jhsd_ctrl.sv */
module jhsd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  jhsd_pkg::jhsd_stat_t stat,
  output jhsd_pkg::jhsd_cmd_t  cmd
);
  import jhsd_pkg::*;

  jhsd_state_t state;
  jhsd_state_t state_next;
  logic [2:0]  bit_cnt;
  logic        step_ok;

  // A bit may be decoded unless a finished result is held and the output is full.
  assign step_ok = !(stat.held_valid && !stat.out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_cnt <= 3'd0;
    end else begin
      state <= state_next;
      if (cmd.accept) begin
        bit_cnt <= 3'd0;
      end else if (cmd.step) begin
        bit_cnt <= bit_cnt + 3'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (stat.action == ACT_BYTE) begin
            state_next = ST_BITS;
          end else if (stat.action == ACT_MARK) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_BITS: begin
        if (step_ok && bit_cnt == 3'd7) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stat.held_valid || stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.step   = 1'b0;
    cmd.flush  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_BITS: begin
        cmd.step = step_ok;
      end
      ST_FLUSH: begin
        cmd.flush = stat.held_valid && stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

/* sv/jhsd_dp.sv */
module jhsd_dp #(
  parameter int MAX_CODE_BITS = 16,
  parameter int SYMBOL_SLOTS  = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  jhsd_pkg::jhsd_cmd_t cmd,
  input  logic [15:0]         s_tdata,
  input  logic [1:0]          s_tuser,
  output jhsd_pkg::jhsd_stat_t stat,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic [1:0]          m_tuser,
  output logic                m_tlast
);
  import jhsd_pkg::*;

  localparam int AW = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;

  // Length tables, one entry per code length.
  logic [TAB_W-1:0] max_code [COUNT_ENTRIES];
  logic [TAB_W-1:0] offset   [COUNT_ENTRIES];
  logic [7:0]       sym_mem  [SYMBOL_SLOTS];

  logic [TAB_W-1:0]       build_code;
  logic [BUILD_CNT_W-1:0] build_count;
  logic [CODE_W-1:0]      code_accum;
  logic [LEN_W-1:0]       code_length;
  logic                   pending_ff;
  logic [7:0]             shift;
  logic                   held_valid;
  logic [1:0]             held_status;
  logic [7:0]             sym_rd;

  logic [1:0] kind;
  logic [7:0] idx;
  logic [7:0] val;

  logic [TAB_W-1:0]       base_code;
  logic [BUILD_CNT_W-1:0] base_count;
  logic [TAB_W-1:0]       li_ext;

  logic [CODE_W-1:0] new_accum;
  logic [LEN_W-1:0]  new_len;
  logic [TAB_W-1:0]  cur_max;
  logic [TAB_W-1:0]  slot;
  logic              code_match;
  logic              slot_ok;
  logic              bit_res;
  logic [1:0]        bit_status;
  logic              out_free;

  assign kind = s_tuser;
  assign idx  = s_tdata[7:0];
  assign val  = s_tdata[15:8];

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    stat.action     = ACT_NONE;
    stat.held_valid = held_valid;
    stat.out_free   = out_free;
    if (kind == KIND_SCAN) begin
      if (pending_ff) begin
        if (val == 8'h00) begin
          stat.action = ACT_BYTE;
        end else if (val != BYTE_FF && val != MARK_DNL) begin
          stat.action = ACT_MARK;
        end
      end else if (val != BYTE_FF) begin
        stat.action = ACT_BYTE;
      end
    end
  end

  // Count load arithmetic.
  assign base_code  = (idx == 8'd0) ? '0 : build_code;
  assign base_count = (idx == 8'd0) ? '0 : build_count;
  assign li_ext     = {{(TAB_W-8){1'b0}}, val};

  // One bit of decoding against the table entry for the current length.
  assign new_accum  = {code_accum[CODE_W-2:0], shift[7]};
  assign new_len    = code_length + LEN_W'(1);
  assign cur_max    = max_code[code_length[3:0]];
  assign code_match = !cur_max[TAB_W-1] && ({1'b0, new_accum} <= cur_max);
  assign slot       = {1'b0, new_accum} + offset[code_length[3:0]];
  assign slot_ok    = slot < TAB_W'(SYMBOL_SLOTS);
  assign bit_res    = code_match || (new_len >= LEN_W'(MAX_CODE_BITS));
  assign bit_status = (code_match && slot_ok) ? STAT_SYMBOL : STAT_INVALID;

  always_ff @(posedge clk) begin
    if (cmd.accept && kind == KIND_SYMBOL &&
        {1'b0, idx} < (BUILD_CNT_W)'(SYMBOL_SLOTS)) begin
      sym_mem[idx[AW-1:0]] <= val;
    end
    if (cmd.step && bit_res && code_match && slot_ok) begin
      sym_rd <= sym_mem[slot[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COUNT_ENTRIES; i++) begin
        max_code[i] <= '1;
        offset[i]   <= '0;
      end
      build_code  <= '0;
      build_count <= '0;
      code_accum  <= '0;
      code_length <= '0;
      pending_ff  <= 1'b0;
      held_valid  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (kind == KIND_COUNT && idx < 8'(COUNT_ENTRIES)) begin
          if (val != 8'd0) begin
            offset[idx[3:0]]   <= TAB_W'(base_count) - base_code;
            max_code[idx[3:0]] <= base_code + li_ext - TAB_W'(1);
            build_count        <= base_count + BUILD_CNT_W'(val);
            build_code         <= (base_code + li_ext) << 1;
          end else begin
            max_code[idx[3:0]] <= '1;
            build_count        <= base_count;
            build_code         <= base_code << 1;
          end
        end
        if (kind == KIND_SCAN) begin
          pending_ff <= (val == BYTE_FF);
          shift      <= pending_ff ? BYTE_FF : val;
        end
        if (stat.action == ACT_MARK) begin
          held_valid  <= 1'b1;
          held_status <= (val == MARK_EOI) ? STAT_EOI : STAT_UNKNOWN;
          code_accum  <= '0;
          code_length <= '0;
        end
      end

      if (cmd.step) begin
        shift <= {shift[6:0], 1'b0};
        if (bit_res) begin
          code_accum  <= '0;
          code_length <= '0;
          held_valid  <= 1'b1;
          held_status <= bit_status;
        end else begin
          code_accum  <= new_accum;
          code_length <= new_len;
        end
      end

      // Output register: the held result moves out on flush (last of the
      // byte) or when a newer result displaces it (not last).
      if (cmd.flush) begin
        m_tvalid   <= 1'b1;
        m_tuser    <= held_status;
        m_tdata    <= (held_status == STAT_SYMBOL) ? sym_rd : 8'd0;
        m_tlast    <= 1'b1;
        held_valid <= 1'b0;
      end else if (cmd.step && bit_res && held_valid) begin
        m_tvalid <= 1'b1;
        m_tuser  <= held_status;
        m_tdata  <= (held_status == STAT_SYMBOL) ? sym_rd : 8'd0;
        m_tlast  <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
